// File: hdl/bmhq_pkg.sv
// Shared types and codes for the binary max-heap priority queue.
package bmhq_pkg;

    localparam int ID_W    = 16;
    localparam int PRI_W   = 32;
    localparam int IDX_W   = 8;
    localparam int COUNT_W = 9;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_RAISE  = 2'd2,
        REQ_LOWER  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_FULL   = 2'd2,
        ST_RANGE  = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0]              req_type;
        logic [ID_W-1:0]         item_id;
        logic signed [PRI_W-1:0] priority_req;
        logic [IDX_W-1:0]        heap_index;
    } t_in_word;

    typedef struct packed {
        logic [1:0]              status;
        logic [ID_W-1:0]         out_id;
        logic signed [PRI_W-1:0] out_priority;
        logic [COUNT_W-1:0]      count;
    } t_out_word;

    typedef struct packed {
        logic [ID_W-1:0]         id;
        logic signed [PRI_W-1:0] pri;
    } t_entry;

endpackage

// File: hdl/bmhq_mem.sv
// Dual-port heap entry store: two write ports, two registered read ports.
module bmhq_mem
    import bmhq_pkg::*;
#(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          i_clk,
    input  logic          i_we_a,
    input  logic [AW-1:0] i_waddr_a,
    input  t_entry        i_wdata_a,
    input  logic          i_we_b,
    input  logic [AW-1:0] i_waddr_b,
    input  t_entry        i_wdata_b,
    input  logic [AW-1:0] i_raddr_a,
    input  logic [AW-1:0] i_raddr_b,
    output t_entry        o_rdata_a,
    output t_entry        o_rdata_b
);

    t_entry r_mem [DEPTH];

    // Write both ports, read both ports
    always_ff @(posedge i_clk) begin
        if (i_we_a) begin
            r_mem[i_waddr_a] <= i_wdata_a;
        end
        if (i_we_b) begin
            r_mem[i_waddr_b] <= i_wdata_b;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

// File: hdl/binary_max_heap_queue.sv
// Binary max-heap priority queue top level: sequencer around the entry store.
// One request is taken at a time. Insert and remove go through the store at
// the end of the heap; raise key and lower key first fetch the entry at the
// given index so that its id is kept. Sift-up walks one level at a time
// (read the parent, then compare and move). Sift-down walks one level at a
// time (read both children on the two read ports, then compare and move).
// Remove and key change first pass through a fetch state. Error cases give
// the result in the cycle after acceptance. The result sits in an output
// register; the next request is taken in the cycle after it leaves.
// Entries are never cleared; only positions below the count are used.
module binary_max_heap_queue
    import bmhq_pkg::*;
#(
    parameter int CAPACITY = 256
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    localparam int AW = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_FETCH  = 7'b0000010,
        S_UPRD   = 7'b0000100,
        S_UPCMP  = 7'b0001000,
        S_DNRD   = 7'b0010000,
        S_DNCMP  = 7'b0100000,
        S_OUT    = 7'b1000000
    } t_state;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic [CW-1:0]   r_pos, n_pos;
    t_entry          r_cur, n_cur;
    t_out_word       r_out, n_out;
    t_req            r_req, n_req;

    logic            we_a, we_b;
    logic [AW-1:0]   waddr_a, waddr_b, raddr_a, raddr_b;
    t_entry          wdata_a, wdata_b, rdata_a, rdata_b;

    logic [CW:0]     left_w, right_w, parent_w;
    logic            l_ok, r_ok, pick_r, pick_l;
    t_in_word        req;

    assign req = i_in_word;

    bmhq_mem #(.DEPTH(CAPACITY), .AW(AW)) u_mem (
        .i_clk     (i_clk),
        .i_we_a    (we_a),
        .i_waddr_a (waddr_a),
        .i_wdata_a (wdata_a),
        .i_we_b    (we_b),
        .i_waddr_b (waddr_b),
        .i_wdata_b (wdata_b),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_out_word  = r_out;

    assign left_w   = {r_pos, 1'b1};
    assign right_w  = {r_pos, 1'b0} + {{CW{1'b0}}, 1'b1} + {{CW{1'b0}}, 1'b1};
    assign parent_w = {1'b0, r_pos} - {{CW{1'b0}}, 1'b1};
    assign r_ok     = right_w < {1'b0, r_cnt};
    assign l_ok     = left_w < {1'b0, r_cnt};
    assign pick_r   = r_ok && (rdata_b.pri > r_cur.pri);
    assign pick_l   = l_ok && (pick_r ? (rdata_a.pri >= rdata_b.pri)
                                      : (rdata_a.pri >= r_cur.pri));

    // Sequence one request through the store
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_pos   = r_pos;
        n_cur   = r_cur;
        n_out   = r_out;
        n_req   = r_req;
        we_a    = 1'b0;
        we_b    = 1'b0;
        waddr_a = r_pos[AW-1:0];
        waddr_b = r_pos[AW-1:0];
        wdata_a = r_cur;
        wdata_b = r_cur;
        raddr_a = left_w[AW-1:0];
        raddr_b = right_w[AW-1:0];
        case (r_state)
            S_IDLE: begin
                // fetch the root and last entry, or the entry at the index
                raddr_a = (req.req_type == REQ_REMOVE) ? '0 : AW'(req.heap_index);
                raddr_b = AW'(r_cnt - {{(CW-1){1'b0}}, 1'b1});
                if (i_in_valid) begin
                    n_out        = '0;
                    n_out.count  = COUNT_W'(r_cnt);
                    n_cur.id     = req.item_id;
                    n_cur.pri    = req.priority_req;
                    n_req        = t_req'(req.req_type);
                    case (t_req'(req.req_type))
                        REQ_INSERT: begin
                            if (r_cnt >= CW'(CAPACITY)) begin
                                n_out.status = ST_FULL;
                                n_state      = S_OUT;
                            end else begin
                                n_pos   = r_cnt;
                                n_cnt   = r_cnt + {{(CW-1){1'b0}}, 1'b1};
                                n_state = S_UPRD;
                            end
                        end
                        REQ_REMOVE: begin
                            if (r_cnt == '0) begin
                                n_out.status = ST_EMPTY;
                                n_state      = S_OUT;
                            end else begin
                                n_cnt   = r_cnt - {{(CW-1){1'b0}}, 1'b1};
                                n_pos   = '0;
                                n_state = S_FETCH;
                            end
                        end
                        default: begin
                            if (32'(req.heap_index) >= 32'(r_cnt)) begin
                                n_out.status = ST_RANGE;
                                n_state      = S_OUT;
                            end else begin
                                n_pos   = CW'(req.heap_index);
                                n_state = S_FETCH;
                            end
                        end
                    endcase
                end
            end
            S_FETCH: begin
                if (r_req == REQ_REMOVE) begin
                    // return the root, move the last entry to the top
                    n_out.out_id       = rdata_a.id;
                    n_out.out_priority = rdata_a.pri;
                    n_cur              = rdata_b;
                    n_state            = S_DNRD;
                end else begin
                    // keep the id stored at the index
                    n_cur.id = rdata_a.id;
                    n_state  = (r_req == REQ_RAISE) ? S_UPRD : S_DNRD;
                end
            end
            S_UPRD: begin
                // read parent of the hole
                raddr_a = AW'(parent_w[CW:1]);
                if (r_pos == '0) begin
                    we_a    = 1'b1;
                    n_state = S_OUT;
                    n_out.count = COUNT_W'(r_cnt);
                end else begin
                    n_state = S_UPCMP;
                end
            end
            S_UPCMP: begin
                if (r_cur.pri > rdata_a.pri) begin
                    // move parent down into the hole
                    we_a    = 1'b1;
                    wdata_a = rdata_a;
                    n_pos   = CW'(parent_w[CW:1]);
                    n_state = S_UPRD;
                end else begin
                    we_a    = 1'b1;
                    n_out.count = COUNT_W'(r_cnt);
                    n_state = S_OUT;
                end
            end
            S_DNRD: begin
                n_state = S_DNCMP;
            end
            S_DNCMP: begin
                if (pick_l) begin
                    we_a    = 1'b1;
                    wdata_a = rdata_a;
                    n_pos   = CW'(left_w);
                    n_state = S_DNRD;
                end else if (pick_r) begin
                    we_a    = 1'b1;
                    wdata_a = rdata_b;
                    n_pos   = CW'(right_w);
                    n_state = S_DNRD;
                end else begin
                    we_a    = 1'b1;
                    n_out.count = COUNT_W'(r_cnt);
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state and result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
        r_pos <= n_pos;
        r_cur <= n_cur;
        r_out <= n_out;
        r_req <= n_req;
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(CAPACITY)) else $error("count beyond capacity");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready) else $error("busy overlap");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid) else $error("result dropped");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> $stable(o_out_word))
        else $error("result changed while held");
endmodule

// File: dv/binary_max_heap_queue_tb.sv
// Testbench for the binary max-heap priority queue: scoreboard class and stimulus.
`timescale 1ns / 100ps

module binary_max_heap_queue_tb
    import bmhq_pkg::*;
();

    localparam int CAP       = 256;
    localparam int MAX_CYC   = 1000000;
    localparam int N_RANDOM  = 500;

    // Track heap contents and check each returned word against the prediction
    class heap_scoreboard;
        logic [ID_W-1:0]         ids [CAP];
        logic signed [PRI_W-1:0] pris [CAP];
        int unsigned             fill;
        t_out_word               pending [$];
        int                      errors;

        function void swap_at(int a, int b);
            logic [ID_W-1:0]         ti;
            logic signed [PRI_W-1:0] tp;
            ti = ids[a];
            tp = pris[a];
            ids[a] = ids[b];
            pris[a] = pris[b];
            ids[b] = ti;
            pris[b] = tp;
        endfunction

        function void bubble_up(int i);
            int p;
            while (i != 0) begin
                p = (i - 1) / 2;
                if (pris[i] > pris[p]) begin
                    swap_at(i, p);
                    i = p;
                end else begin
                    break;
                end
            end
        endfunction

        function void bubble_down(int i);
            int best, l, r;
            forever begin
                best = i;
                l = 2 * i + 1;
                r = 2 * i + 2;
                if (r < fill && pris[r] > pris[i]) best = r;
                if (l < fill && pris[l] >= pris[best]) best = l;
                if (best == i) break;
                swap_at(i, best);
                i = best;
            end
        endfunction

        // Apply one accepted request and queue the word it should produce
        function void note_request(t_in_word w);
            t_out_word o;
            o = '0;
            o.status = ST_OK;
            case (t_req'(w.req_type))
                REQ_INSERT: begin
                    if (fill >= CAP) begin
                        o.status = ST_FULL;
                    end else begin
                        ids[fill] = w.item_id;
                        pris[fill] = w.priority_req;
                        bubble_up(fill);
                        fill++;
                    end
                end
                REQ_REMOVE: begin
                    if (fill == 0) begin
                        o.status = ST_EMPTY;
                    end else begin
                        o.out_id = ids[0];
                        o.out_priority = pris[0];
                        fill--;
                        ids[0] = ids[fill];
                        pris[0] = pris[fill];
                        bubble_down(0);
                    end
                end
                default: begin
                    if (w.heap_index >= fill) begin
                        o.status = ST_RANGE;
                    end else begin
                        pris[w.heap_index] = w.priority_req;
                        if (t_req'(w.req_type) == REQ_RAISE) bubble_up(w.heap_index);
                        else bubble_down(w.heap_index);
                    end
                end
            endcase
            o.count = fill[COUNT_W-1:0];
            pending.push_back(o);
        endfunction

        // Compare one returned word with the oldest prediction
        function void check_word(t_out_word a);
            t_out_word e;
            if (pending.size() == 0) begin
                $error("unexpected output word %h", a);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (a.status !== e.status) begin
                $error("status exp %0d got %0d", e.status, a.status);
                errors++;
            end
            if (a.out_id !== e.out_id) begin
                $error("out_id exp %0d got %0d", e.out_id, a.out_id);
                errors++;
            end
            if (a.out_priority !== e.out_priority) begin
                $error("out_priority exp %0d got %0d", e.out_priority, a.out_priority);
                errors++;
            end
            if (a.count !== e.count) begin
                $error("count exp %0d got %0d", e.count, a.count);
                errors++;
            end
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_word  i_in_word;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_word o_out_word;

    heap_scoreboard sb;
    int             cycles;
    bit             stim_done;

    binary_max_heap_queue #(.CAPACITY(CAP)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_word = '0;
        i_out_ready = 1'b0;
        sb = new();
        stim_done = 1'b0;
        cycles = 0;
    end

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Count cycles and abort on a hang
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= MAX_CYC) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Note accepted requests and check accepted results
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) sb.note_request(i_in_word);
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_word(o_out_word);
    end

    // Result side: random stall per word, with calm stretches
    initial begin : out_side
        int gap;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
            repeat (gap) @(posedge i_clk);
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            i_out_ready <= 1'b0;
        end
    end

    // Offer one word and hold it until accepted
    task automatic send_word(input t_req rq, input logic [ID_W-1:0] id,
                             input logic signed [PRI_W-1:0] pr,
                             input logic [IDX_W-1:0] ix, input bit idle);
        int gap;
        t_in_word w;
        gap = idle ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        w.req_type = rq;
        w.item_id = id;
        w.priority_req = pr;
        w.heap_index = ix;
        i_in_valid <= 1'b1;
        i_in_word <= w;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic drain_all();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic signed [PRI_W-1:0] rand_pri();
        case ($urandom_range(0, 5))
            0: return 32'sh7FFFFFFF;
            1: return 32'sh80000000;
            2: return $signed(32'($urandom_range(0, 7)));
            default: return $signed($urandom());
        endcase
    endfunction

    initial begin : stimulus
        int k, mode, limit;
        bit idle;
        t_req rq;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty heap errors, extremes, ties, key changes both ways
        send_word(REQ_REMOVE, 16'hFFFF, 32'sh7FFFFFFF, 8'hFF, 1'b0);
        send_word(REQ_RAISE, 16'h0, 32'sh0, 8'h0, 1'b0);
        send_word(REQ_LOWER, 16'h0, 32'sh0, 8'h0, 1'b0);
        send_word(REQ_INSERT, 16'hFFFF, 32'sh7FFFFFFF, 8'h00, 1'b0);
        send_word(REQ_INSERT, 16'h0000, 32'sh80000000, 8'hFF, 1'b0);
        send_word(REQ_INSERT, 16'h1234, 32'sh5, 8'h0, 1'b0);
        send_word(REQ_INSERT, 16'h1235, 32'sh5, 8'h0, 1'b0);
        send_word(REQ_INSERT, 16'h1236, 32'sh5, 8'h0, 1'b0);
        send_word(REQ_RAISE, 16'h0, 32'sh80000000, 8'd2, 1'b0);
        send_word(REQ_LOWER, 16'h0, 32'sh7FFFFFFF, 8'd3, 1'b0);
        send_word(REQ_LOWER, 16'h0, 32'sh80000000, 8'd0, 1'b0);
        send_word(REQ_RAISE, 16'h0, 32'sh7FFFFFFF, 8'd4, 1'b0);
        send_word(REQ_RAISE, 16'h0, 32'sh0, 8'd5, 1'b0);
        send_word(REQ_LOWER, 16'h0, 32'sh0, 8'hFF, 1'b0);
        for (k = 0; k < 6; k++) send_word(REQ_REMOVE, 16'h0, 32'sh0, 8'h0, 1'b0);
        drain_all();

        // Fill to capacity, overflow, then lower and raise a key and empty it again
        for (k = 0; k < CAP; k++)
            send_word(REQ_INSERT, 16'($urandom()), rand_pri(), 8'($urandom()), 1'b0);
        send_word(REQ_INSERT, 16'hABCD, 32'sh1, 8'h0, 1'b0);
        send_word(REQ_LOWER, 16'h0, 32'sh80000000, 8'hFF, 1'b0);
        send_word(REQ_RAISE, 16'h0, 32'sh7FFFFFFF, 8'hFF, 1'b0);
        for (k = 0; k < CAP + 1; k++) send_word(REQ_REMOVE, 16'h0, 32'sh0, 8'h0, 1'b1);
        drain_all();

        // Random phases: biased toward growth, shrink, or balanced traffic
        for (k = 0; k < N_RANDOM; k++) begin
            if (k % 200 == 0) mode = $urandom_range(0, 2);
            idle = ($urandom_range(0, 4) != 0);
            case ($urandom_range(0, 9))
                0, 1, 2: rq = (mode == 1) ? REQ_REMOVE : REQ_INSERT;
                3, 4:    rq = (mode == 0) ? REQ_INSERT : REQ_REMOVE;
                5, 6:    rq = REQ_RAISE;
                7, 8:    rq = REQ_LOWER;
                default: rq = t_req'($urandom_range(0, 3));
            endcase
            limit = (sb.fill == 0) ? 255 : (($urandom_range(0, 7) == 0) ? 255 : sb.fill - 1);
            send_word(rq, 16'($urandom()), rand_pri(), 8'($urandom_range(0, limit)), idle);
            if (k == N_RANDOM / 2) drain_all();
        end

        // Wait for every result, then a short tail
        drain_all();
        repeat (40) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// File: sim.f
hdl/bmhq_pkg.sv
hdl/bmhq_mem.sv
hdl/binary_max_heap_queue.sv
dv/binary_max_heap_queue_tb.sv
